/* design/dcnc_pkg.sv */
// Shared types and codes for the dual chirp normalized correlator.
package dcnc_pkg;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;
    localparam logic [1:0] ACT_DOWN   = 2'd2;
    localparam logic [1:0] ACT_SKIP   = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic [23:0]        power;
        logic [7:0]         tap_index;
        logic signed [15:0] tap_re;
        logic signed [15:0] tap_im;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] ratio_up;
        logic signed [31:0] ratio_down;
        logic               power_zero;
        logic               saturated;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PSUM,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

/* design/dcnc_ram.sv */
// Generic simple dual-port RAM with registered read, old data on a same-address write.
module dcnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/dcnc_mac.sv */
// Two-stage multiply-accumulate of the real part of sample times conjugate tap, for the up and down chirp correlations.
module dcnc_mac #(
    parameter int CW = 41
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 valid,
    input  logic [31:0]          sample,
    input  logic [31:0]          up_tap,
    input  logic [31:0]          down_tap,
    output logic                 busy,
    output logic signed [CW-1:0] corr_up,
    output logic signed [CW-1:0] corr_down
);
    logic signed [31:0] p_ur_reg, p_ui_reg, p_dr_reg, p_di_reg;
    logic               v_reg;
    logic signed [CW-1:0] acc_up_reg, acc_down_reg;
    logic signed [15:0] xr, xi, ur, ui, dr, di;

    assign xr = sample[31:16];
    assign xi = sample[15:0];
    assign ur = up_tap[31:16];
    assign ui = up_tap[15:0];
    assign dr = down_tap[31:16];
    assign di = down_tap[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= valid && !clear;
        end
    end

    always_ff @(posedge clk)
    begin
        p_ur_reg <= xr * ur;
        p_ui_reg <= xi * ui;
        p_dr_reg <= xr * dr;
        p_di_reg <= xi * di;
        if (clear)
        begin
            acc_up_reg   <= '0;
            acc_down_reg <= '0;
        end
        else if (v_reg)
        begin
            acc_up_reg   <= acc_up_reg + CW'(p_ur_reg) + CW'(p_ui_reg);
            acc_down_reg <= acc_down_reg + CW'(p_dr_reg) + CW'(p_di_reg);
        end
    end

    assign busy      = v_reg;
    assign corr_up   = acc_up_reg;
    assign corr_down = acc_down_reg;
endmodule

/* design/dcnc_ratio.sv */
// Bit-serial signed Q16.16 ratio with saturation: corr * 65536 / psum.
module dcnc_ratio #(
    parameter int CW = 41,
    parameter int VW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] corr,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic signed [31:0]   ratio,
    output logic                 sat
);
    localparam int DW = CW + 16;
    localparam int KW = $clog2(DW + 1);
    localparam logic [DW-1:0] LIM = DW'(64'h8000_0000);

    logic [DW-1:0] sh_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dv_reg;
    logic          neg_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] mag;
    logic [VW:0]   trial;
    logic          ge;

    assign mag   = corr[CW-1] ? CW'(-corr) : CW'(corr);
    assign trial = {rem_reg[VW-1:0], sh_reg[DW-1]};
    assign ge    = trial >= {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == KW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {mag, 16'b0};
            rem_reg <= '0;
            dv_reg  <= divisor;
            neg_reg <= corr[CW-1];
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DW-2:0], ge};
            rem_reg <= ge ? trial - {1'b0, dv_reg} : trial;
        end
    end

    always_comb
    begin
        sat   = 1'b0;
        ratio = '0;
        if (neg_reg)
        begin
            if (sh_reg > LIM)
            begin
                sat   = 1'b1;
                ratio = 32'sh8000_0000;
            end
            else
            begin
                ratio = -$signed(sh_reg[31:0]);
            end
        end
        else
        begin
            if (sh_reg >= LIM)
            begin
                sat   = 1'b1;
                ratio = 32'sh7fff_ffff;
            end
            else
            begin
                ratio = $signed(sh_reg[31:0]);
            end
        end
    end

    assign done = done_reg;
endmodule

/* design/dual_chirp_normalized_correlator.sv */
// Top level of the dual chirp normalized correlator.
// Input words on in_valid/in_ready carry an action: a sample with its power, one up
// or down chirp tap load, or a skip, which is taken and dropped. A tap load is taken
// while idle and the block stays idle. A sample is written to the history RAM; once
// the window of N samples is full (N = window_length, 0 read as 1, capped at MAX_TAPS),
// each sample yields one output word on out_valid/out_ready with both Q16.16 ratios.
// A sample without a result passes through PSUM back to idle; one with a result goes
// through PSUM, the multiply-accumulate pass with one history RAM read per tap,
// bit-serial division and OUT. A zero power sum skips the division. One word is
// worked on at a time; in_ready is high only while idle.
// The output register holds a finished word while the receiver stalls; the next
// sample may be taken meanwhile and waits for it only at its own end.
// Reset clears the window, sets window_length to 256 and leaves taps undefined
// until loaded. A write on cfg_valid/cfg_ready, taken only while idle, sets
// window_length and restarts the window; taps are kept. No clearing pass.
module dual_chirp_normalized_correlator #(
    parameter int MAX_TAPS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcnc_pkg::in_word_t in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output dcnc_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import dcnc_pkg::*;

    localparam int AW  = $clog2(MAX_TAPS);
    localparam int NW  = $clog2(MAX_TAPS + 1);
    localparam int CW  = 33 + AW;
    localparam int PSW = 24 + AW;

    state_t state_reg, state_next;
    logic [8:0]     wl_reg;
    logic [NW-1:0]  fill_reg;
    logic [AW-1:0]  wp_reg;
    logic [PSW-1:0] psum_reg, psum_next;
    logic           full_reg, res_reg;
    logic [23:0]    pw_reg;
    logic [AW-1:0]  ptr_reg;
    logic [NW-1:0]  cnt_reg;
    logic           iss_reg;
    logic           out_valid_reg;
    out_word_t      out_reg;

    logic [NW-1:0]  n_eff;
    logic           accept, cfg_accept, issue, load_out, full_now, res_now;
    logic           tap_ok, mac_clear, div_start, mac_busy;
    logic [AW-1:0]  hist_raddr, oldest, start_ptr, wp_inc, ptr_inc;
    logic [55:0]    hist_rdata;
    logic [31:0]    up_rdata, down_rdata;
    logic signed [CW-1:0] corr_up, corr_down;
    logic           up_done, down_done, up_sat, down_sat;
    logic signed [31:0] ratio_up, ratio_down;

    function automatic logic [AW-1:0] back(input logic [AW-1:0] p, input logic [NW-1:0] n);
        logic [AW+1:0] t;
        t = {2'b0, p} + (AW+2)'(MAX_TAPS) - (AW+2)'(n);
        if (t >= (AW+2)'(MAX_TAPS))
        begin
            t = t - (AW+2)'(MAX_TAPS);
        end
        return t[AW-1:0];
    endfunction

    always_comb
    begin
        if (wl_reg == 9'd0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(wl_reg) > MAX_TAPS)
        begin
            n_eff = NW'(MAX_TAPS);
        end
        else
        begin
            n_eff = NW'(wl_reg);
        end
    end

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign in_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign accept     = in_valid && in_ready;
    assign tap_ok     = 32'(in_word.tap_index) < MAX_TAPS;
    assign full_now   = fill_reg >= n_eff;
    assign res_now    = ({1'b0, fill_reg} + 1'b1) >= {1'b0, n_eff};
    assign wp_inc     = (32'(wp_reg) == MAX_TAPS - 1) ? '0 : wp_reg + 1'b1;
    assign ptr_inc    = (32'(ptr_reg) == MAX_TAPS - 1) ? '0 : ptr_reg + 1'b1;
    assign oldest     = back(wp_reg, n_eff);
    assign start_ptr  = back(wp_reg, n_eff);
    assign issue      = (state_reg == ST_MAC) && (cnt_reg < n_eff);
    assign hist_raddr = (state_reg == ST_IDLE) ? oldest : ptr_reg;
    assign load_out   = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    dcnc_ram #(.WIDTH(56), .DEPTH(MAX_TAPS)) u_hist (
        .clk   (clk),
        .we    (accept && in_word.action == ACT_SAMPLE),
        .waddr (wp_reg),
        .wdata ({in_word.sample_re, in_word.sample_im, in_word.power}),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    dcnc_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_up (
        .clk   (clk),
        .we    (accept && in_word.action == ACT_UP && tap_ok),
        .waddr (AW'(in_word.tap_index)),
        .wdata ({in_word.tap_re, in_word.tap_im}),
        .raddr (AW'(cnt_reg)),
        .rdata (up_rdata)
    );

    dcnc_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_down (
        .clk   (clk),
        .we    (accept && in_word.action == ACT_DOWN && tap_ok),
        .waddr (AW'(in_word.tap_index)),
        .wdata ({in_word.tap_re, in_word.tap_im}),
        .raddr (AW'(cnt_reg)),
        .rdata (down_rdata)
    );

    dcnc_mac #(.CW(CW)) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (mac_clear),
        .valid     (iss_reg),
        .sample    (hist_rdata[55:24]),
        .up_tap    (up_rdata),
        .down_tap  (down_rdata),
        .busy      (mac_busy),
        .corr_up   (corr_up),
        .corr_down (corr_down)
    );

    dcnc_ratio #(.CW(CW), .VW(PSW)) u_ratio_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .corr    (corr_up),
        .divisor (psum_reg),
        .done    (up_done),
        .ratio   (ratio_up),
        .sat     (up_sat)
    );

    dcnc_ratio #(.CW(CW), .VW(PSW)) u_ratio_down (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .corr    (corr_down),
        .divisor (psum_reg),
        .done    (down_done),
        .ratio   (ratio_down),
        .sat     (down_sat)
    );

    always_comb
    begin
        state_next = state_reg;
        psum_next  = psum_reg;
        mac_clear  = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_accept)
                begin
                    psum_next = '0;
                end
                if (accept && in_word.action == ACT_SAMPLE)
                begin
                    state_next = ST_PSUM;
                end
            end
            ST_PSUM:
            begin
                psum_next = psum_reg - (full_reg ? PSW'(hist_rdata[23:0]) : '0)
                            + PSW'(pw_reg);
                mac_clear = 1'b1;
                state_next = res_reg ? ST_MAC : ST_IDLE;
            end
            ST_MAC:
            begin
                if (!issue && !iss_reg && !mac_busy)
                begin
                    if (psum_reg == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (up_done && down_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= 9'd256;
            fill_reg      <= '0;
            wp_reg        <= '0;
            psum_reg      <= '0;
            full_reg      <= 1'b0;
            res_reg       <= 1'b0;
            cnt_reg       <= '0;
            iss_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            psum_reg  <= psum_next;
            iss_reg   <= issue;
            if (cfg_accept)
            begin
                wl_reg   <= cfg_data;
                fill_reg <= '0;
                wp_reg   <= '0;
            end
            if (accept && in_word.action == ACT_SAMPLE)
            begin
                full_reg <= full_now;
                res_reg  <= res_now;
                wp_reg   <= wp_inc;
                if (!full_now)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (state_reg == ST_PSUM)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pw_reg <= in_word.power;
        end
        if (state_reg == ST_PSUM)
        begin
            ptr_reg <= start_ptr;
        end
        else if (issue)
        begin
            ptr_reg <= ptr_inc;
        end
        if (load_out)
        begin
            if (psum_reg == '0)
            begin
                out_reg.ratio_up   <= '0;
                out_reg.ratio_down <= '0;
                out_reg.power_zero <= 1'b1;
                out_reg.saturated  <= 1'b0;
            end
            else
            begin
                out_reg.ratio_up   <= ratio_up;
                out_reg.ratio_down <= ratio_down;
                out_reg.power_zero <= 1'b0;
                out_reg.saturated  <= up_sat || down_sat;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
endmodule
